@@ hdl/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg
// Shared widths, codes and types of the integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int DIM_DEFAULT = 8;
  localparam int OP_W        = 2;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int VALUE_W     = 16;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int SUM_W       = 36;
  localparam int ROWS_W      = 4;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_WAIT,
    WALK_ISSUE
  } walk_state_t;

  // One read slot issued by the walk, carried down the accumulate pipeline.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } mac_ctrl_t;

endpackage

@@ hdl/imm_if.sv @@
// ----------------------------------------------------------------------------
// imm_if
// Request and response channels of the integer matrix multiply block.
// ----------------------------------------------------------------------------
interface imm_req_if;
  import imm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [ROW_W-1:0]          row;
  logic [COL_W-1:0]          col;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, operation, row, col, value, input ready);
  modport sink (input valid, operation, row, col, value, output ready);
endinterface

interface imm_rsp_if;
  import imm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic signed [SUM_W-1:0] product_sum;
  logic                    last;

  modport source (output valid, out_row, out_col, product_sum, last, input ready);
  modport sink (input valid, out_row, out_col, product_sum, last, output ready);
endinterface

@@ hdl/imm_ram.sv @@
// ----------------------------------------------------------------------------
// imm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = imm_pkg::VALUE_W,
  parameter int DEPTH = imm_pkg::DIM_DEFAULT * imm_pkg::DIM_DEFAULT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/imm_walk.sv @@
// ----------------------------------------------------------------------------
// imm_walk
// Sequencer: walks C element by element and issues the A and B reads.
// ----------------------------------------------------------------------------
module imm_walk #(
  parameter int DIM   = imm_pkg::DIM_DEFAULT,
  localparam int AW   = $clog2(DIM * DIM)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [imm_pkg::ROWS_W-1:0] rows_eff,
  input  logic                      mac_idle,
  output logic                      busy,
  output imm_pkg::mac_ctrl_t        ctrl,
  output logic [AW-1:0]             a_raddr,
  output logic [AW-1:0]             b_raddr
);
  import imm_pkg::*;

  localparam int IDX_W = $clog2(DIM);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

  walk_state_t      state, state_next;
  logic [IDX_W-1:0] i, j, k;
  logic [IDX_W-1:0] last_row;
  logic             last_elem;

  assign last_elem = (i == last_row) && (j == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WALK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance k fastest, then the column, then the row.
  always_ff @(posedge clk) begin
    if (start) begin
      i        <= '0;
      j        <= '0;
      k        <= '0;
      last_row <= IDX_W'(rows_eff - ROWS_W'(1));
    end else if (state == WALK_ISSUE) begin
      if (k == LAST_IDX) begin
        k <= '0;
        if (j == LAST_IDX) begin
          j <= '0;
          i <= i + IDX_W'(1);
        end else begin
          j <= j + IDX_W'(1);
        end
      end else begin
        k <= k + IDX_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      WALK_IDLE: begin
        if (start) begin
          state_next = WALK_WAIT;
        end
      end
      WALK_WAIT: begin
        if (mac_idle) begin
          state_next = WALK_ISSUE;
        end
      end
      WALK_ISSUE: begin
        if (k == LAST_IDX) begin
          state_next = last_elem ? WALK_IDLE : WALK_WAIT;
        end
      end
      default: state_next = WALK_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state != WALK_IDLE);
    ctrl.valid     = (state == WALK_ISSUE);
    ctrl.first     = (k == '0);
    ctrl.last_k    = (k == LAST_IDX);
    ctrl.last_elem = last_elem;
    ctrl.row       = ROW_W'(i);
    ctrl.col       = COL_W'(j);
    a_raddr        = AW'(i) * AW'(DIM) + AW'(k);
    b_raddr        = AW'(k) * AW'(DIM) + AW'(j);
  end

endmodule

@@ hdl/imm_mac.sv @@
// ----------------------------------------------------------------------------
// imm_mac
// Multiply-accumulate pipeline and result output register.
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  imm_pkg::mac_ctrl_t          ctrl,
  input  logic [imm_pkg::VALUE_W-1:0] a_rdata,
  input  logic [imm_pkg::VALUE_W-1:0] b_rdata,
  output logic                        mac_idle,
  imm_rsp_if.source                   rsp
);
  import imm_pkg::*;

  mac_ctrl_t                s1, s2;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic                     done;
  logic [ROW_W-1:0]         done_row;
  logic [COL_W-1:0]         done_col;
  logic                     done_last;
  logic                     out_valid;
  logic                     load_out;

  assign load_out = done && (!out_valid || rsp.ready);
  assign mac_idle = !s1.valid && !s2.valid && !done;

  // Control stages line up with RAM data, then with the product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= ctrl;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_rdata) * $signed(b_rdata);
    if (s2.valid) begin
      acc <= s2.first ? SUM_W'(prod) : acc + SUM_W'(prod);
    end
  end

  // Hold the finished sum until the output register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (s2.valid && s2.last_k) begin
      done <= 1'b1;
    end else if (load_out) begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2.valid && s2.last_k) begin
      done_row  <= s2.row;
      done_col  <= s2.col;
      done_last <= s2.last_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.out_row     <= done_row;
      rsp.out_col     <= done_col;
      rsp.product_sum <= acc;
      rsp.last        <= done_last;
    end
  end

  assign rsp.valid = out_valid;

endmodule

@@ hdl/integer_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// C = A x B over a DIM x DIM matrix B and up to DIM rows of A, exact sums.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake (valid and ready both high).
//   A load-A or load-B request writes one signed element at (row, col);
//   loads outside the matrix and the unused operation code are dropped.
//   Loads are taken one per cycle whenever the block is idle.
//   A start request walks C in row-major order for rows_in_use rows
//   (saturated to DIM, none at zero) and emits one response per element
//   on rsp, with last set on the final one.
//   Each element takes DIM reads from the A and B RAMs (one read
//   port each) and then passes through the pipeline and handoff; the
//   walk waits for the pipeline and hold register to empty before it
//   starts the next element, so elements never overlap.
//   req.ready is low from a start until its last element has been issued.
//   When rsp stalls, the finished sum waits in a hold register behind the
//   output register and the walk pauses before the next element.
//   Reset clears the control state and sets rows_in_use to 8; the element
//   RAMs keep no reset value and must be loaded before a start.
//   cfg_we writes rows_in_use from cfg_wdata; write it only while idle.
// ----------------------------------------------------------------------------
module integer_matrix_multiply #(
  parameter int DIM = imm_pkg::DIM_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [imm_pkg::ROWS_W-1:0]  cfg_wdata,
  imm_req_if.sink                     req,
  imm_rsp_if.source                   rsp
);
  import imm_pkg::*;

  localparam int AW = $clog2(DIM * DIM);

  logic [ROWS_W-1:0]  rows_in_use;
  logic [ROWS_W-1:0]  rows_eff;
  logic               accept;
  logic               in_range;
  logic [AW-1:0]      waddr;
  logic               a_we, b_we;
  logic               start;
  logic               busy;
  logic               mac_idle;
  mac_ctrl_t          ctrl;
  logic [AW-1:0]      a_raddr, b_raddr;
  logic [VALUE_W-1:0] a_rdata, b_rdata;

  // Row count register; the host writes it only while the block is idle (the block does not enforce this).
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
    end else if (cfg_we) begin
      rows_in_use <= cfg_wdata;
    end
  end

  // Clamp the row count to the rows the RAM holds.
  assign rows_eff = (rows_in_use > ROWS_W'(DIM)) ? ROWS_W'(DIM) : rows_in_use;

  // Take requests only while the walk is not running.
  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;

  // Drop loads that fall outside the DIM x DIM matrix.
  assign in_range = ({1'b0, req.row} < (ROW_W + 1)'(DIM))
                 && ({1'b0, req.col} < (COL_W + 1)'(DIM));
  assign waddr    = AW'(req.row) * AW'(DIM) + AW'(req.col);
  assign a_we     = accept && (req.operation == OP_LOAD_A) && in_range;
  assign b_we     = accept && (req.operation == OP_LOAD_B) && in_range;

  // A start with no rows gives no response and leaves the walk idle.
  assign start = accept && (req.operation == OP_START) && (rows_eff != '0);

  imm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DIM * DIM)
  ) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (req.value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  imm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DIM * DIM)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (req.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  imm_walk #(
    .DIM (DIM)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .rows_eff (rows_eff),
    .mac_idle (mac_idle),
    .busy     (busy),
    .ctrl     (ctrl),
    .a_raddr  (a_raddr),
    .b_raddr  (b_raddr)
  );

  imm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .a_rdata  (a_rdata),
    .b_rdata  (b_rdata),
    .mac_idle (mac_idle),
    .rsp      (rsp)
  );

  // The final response of a run closes a row of C.
  a_last_col : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last) |-> (rsp.out_col == COL_W'(DIM - 1)))
    else $error("last response not at final column");

  // A start with rows to walk blocks further requests.
  a_start_blocks : assert property (@(posedge clk) disable iff (rst)
    start |=> !req.ready)
    else $error("request taken right after start");

  // Responses stay inside the matrix.
  a_row_range : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ({1'b0, rsp.out_row} < (ROW_W + 1)'(DIM)))
    else $error("response row outside matrix");

  // Nothing is written into the element RAMs while a walk runs.
  a_no_write_busy : assert property (@(posedge clk) disable iff (rst)
    busy |-> !(a_we || b_we))
    else $error("element write during walk");

endmodule
